// File: rtl/core/sacl_pkg.sv
// Shared types, constants and helper functions for the set-associative
// cache tag store with LRU ages. No dependencies.
package sacl_pkg;

	localparam int MAX_WAYS     = 8;
	localparam int MAX_SETS     = 1024;
	localparam int ADDR_W       = 32;

	localparam int IN_ADDR_W    = 32;
	localparam int SET_W        = $clog2(MAX_SETS);
	localparam int MAX_IDX_BITS = $clog2(MAX_SETS + 1) - 1;
	localparam int WAY_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int TAG_W        = ADDR_W;
	localparam int AGE_W        = 3;
	localparam int CNT_W        = 32;

	localparam int OFS_W        = 5;
	localparam int IDXB_W       = 4;
	localparam int WAYS_W       = 4;
	localparam int CFG_DATA_W   = 5;
	localparam int CFG_IDX_W    = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INDEX  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS   = 2'd2;

	localparam logic [OFS_W-1:0]  OFS_RESET  = 5'd4;
	localparam logic [IDXB_W-1:0] IDXB_RESET = 4'd10;
	localparam logic [WAYS_W-1:0] WAYS_RESET = 4'd1;

	localparam logic [AGE_W-1:0] AGE_MAX   = '1;
	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic [MAX_WAYS-1:0]             valid;
		logic [MAX_WAYS-1:0][AGE_W-1:0]  age;
		logic [MAX_WAYS-1:0][TAG_W-1:0]  tag;
	} row_t;

	localparam int ROW_W = $bits(row_t);

	typedef struct packed {
		logic clear;
		logic load;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
	} sts_t;

	function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
		return (v == COUNT_MAX) ? v : v + CNT_W'(1);
	endfunction

	function automatic logic [AGE_W-1:0] age_up(input logic [AGE_W-1:0] a);
		return (a == AGE_MAX) ? a : a + AGE_W'(1);
	endfunction

endpackage

// File: rtl/core/set_assoc_cache_lru_lookup.sv
// Set-associative cache tag store with LRU ages: top level.
// After the row read, a commit writes the row back and registers the result;
// it stalls while a shown result is not taken. New addresses wait for commit.
// Reset: config returns to offset 4, index 10, ways 1; counters clear; a
// clearing pass zeroes all MAX_SETS (1024) rows with in_ready low.
// Depends on sacl_pkg, sacl_ctrl, sacl_dp and sacl_ram.
module set_assoc_cache_lru_lookup (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [sacl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sacl_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [sacl_pkg::IN_ADDR_W-1:0]    address,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit,
	output logic [sacl_pkg::WAY_W-1:0]        way,
	output logic [sacl_pkg::SET_W-1:0]        set_index,
	output logic [sacl_pkg::CNT_W-1:0]        access_count,
	output logic [sacl_pkg::CNT_W-1:0]        hit_count,
	output logic [sacl_pkg::CNT_W-1:0]        miss_count
);
	import sacl_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sacl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sacl_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.address      (address),
		.cmd          (cmd),
		.sts          (sts),
		.hit          (hit),
		.way          (way),
		.set_index    (set_index),
		.access_count (access_count),
		.hit_count    (hit_count),
		.miss_count   (miss_count)
	);

endmodule

// File: rtl/core/sacl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sacl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/core/sacl_ctrl.sv
// Controller state machine: clearing pass, input acceptance, commit and
// output valid. Depends on sacl_pkg.
module sacl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  sacl_pkg::sts_t sts,
	output sacl_pkg::cmd_t cmd
);
	import sacl_pkg::*;

	state_t state_q;
	state_t state_n;
	logic   out_valid_q;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clear_last) begin
					state_n = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_n = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (!out_valid_q || out_ready) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd        = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_UPDATE: begin
				cmd.commit = !out_valid_q || out_ready;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear, cmd.load, cmd.commit}))
		else $error("controller issued overlapping commands");

	a_rise_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.commit))
		else $error("result shown without a commit");

	a_ready_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> in_ready)
		else $error("input not reopened after commit");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !in_ready && !cmd.commit)
		else $error("input taken during clearing pass");

endmodule

// File: rtl/core/sacl_dp.sv
// Datapath: configuration registers, address split, tag/age row memory,
// way search, LRU age update and saturating counters.
// Depends on sacl_pkg and sacl_ram.
module sacl_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [sacl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sacl_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [sacl_pkg::IN_ADDR_W-1:0]    address,
	input  sacl_pkg::cmd_t                    cmd,
	output sacl_pkg::sts_t                    sts,
	output logic                              hit,
	output logic [sacl_pkg::WAY_W-1:0]        way,
	output logic [sacl_pkg::SET_W-1:0]        set_index,
	output logic [sacl_pkg::CNT_W-1:0]        access_count,
	output logic [sacl_pkg::CNT_W-1:0]        hit_count,
	output logic [sacl_pkg::CNT_W-1:0]        miss_count
);
	import sacl_pkg::*;

	logic [OFS_W-1:0]  offset_q;
	logic [IDXB_W-1:0] idxb_q;
	logic [WAYS_W-1:0] ways_q;

	logic [ADDR_W-1:0] addr_n;
	logic [ADDR_W-1:0] block_n;
	logic [ADDR_W-1:0] tag_n;
	logic [IDXB_W-1:0] ib_n;
	logic [SET_W-1:0]  set_n;

	logic [SET_W-1:0]  set_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic [SET_W-1:0]  clr_q;

	logic [CNT_W-1:0]  acc_q;
	logic [CNT_W-1:0]  hits_q;
	logic [CNT_W-1:0]  miss_q;
	logic              hit_q;
	logic [WAY_W-1:0]  way_q;
	logic [SET_W-1:0]  set_q;

	logic [ROW_W-1:0]  rdata;
	row_t              rd;
	row_t              nrow;
	logic [WAYS_W-1:0] ways_n;
	logic [MAX_WAYS-1:0] active;
	logic [MAX_WAYS-1:0] match;
	logic [MAX_WAYS-1:0] free;
	logic              hit_n;
	logic              have_free;
	logic [WAY_W-1:0]  hit_way;
	logic [WAY_W-1:0]  free_way;
	logic [WAY_W-1:0]  vic_way;
	logic [WAY_W-1:0]  found;
	logic [AGE_W-1:0]  old_age;

	logic              ram_we;
	logic [SET_W-1:0]  ram_waddr;
	logic [ROW_W-1:0]  ram_wdata;
	logic [SET_W-1:0]  ram_raddr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFS_RESET;
			idxb_q   <= IDXB_RESET;
			ways_q   <= WAYS_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_OFFSET: offset_q <= cfg_data[OFS_W-1:0];
				CFG_INDEX:  idxb_q   <= cfg_data[IDXB_W-1:0];
				CFG_WAYS:   ways_q   <= cfg_data[WAYS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		addr_n  = ADDR_W'(address);
		block_n = addr_n >> offset_q;
		ib_n    = (idxb_q > IDXB_W'(MAX_IDX_BITS)) ? IDXB_W'(MAX_IDX_BITS) : idxb_q;
		set_n   = SET_W'(block_n & ((ADDR_W'(1) << ib_n) - ADDR_W'(1)));
		tag_n   = block_n >> ib_n;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			set_s1 <= set_n;
			tag_s1 <= TAG_W'(tag_n);
		end
	end

	assign rd = row_t'(rdata);

	always_comb begin
		if (ways_q == '0) begin
			ways_n = WAYS_W'(1);
		end else if (ways_q > WAYS_W'(MAX_WAYS)) begin
			ways_n = WAYS_W'(MAX_WAYS);
		end else begin
			ways_n = ways_q;
		end
		for (int w = 0; w < MAX_WAYS; w++) begin
			active[w] = WAYS_W'(w) < ways_n;
			match[w]  = active[w] && rd.valid[w] && (rd.tag[w] == tag_s1);
			free[w]   = active[w] && !rd.valid[w];
		end
	end

	always_comb begin
		hit_way  = '0;
		free_way = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit_way = WAY_W'(w);
			end
			if (free[w]) begin
				free_way = WAY_W'(w);
			end
		end
		hit_n     = |match;
		have_free = |free;
		old_age   = rd.age[hit_way];
	end

	always_comb begin
		vic_way = '0;
		for (int w = 1; w < MAX_WAYS; w++) begin
			if (active[w] && (rd.age[w] > rd.age[vic_way])) begin
				vic_way = WAY_W'(w);
			end
		end
	end

	always_comb begin
		if (hit_n) begin
			found = hit_way;
		end else if (have_free) begin
			found = free_way;
		end else begin
			found = vic_way;
		end
		nrow = rd;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (active[w]) begin
				if (WAY_W'(w) == found) begin
					nrow.age[w] = '0;
					if (!hit_n) begin
						nrow.valid[w] = 1'b1;
						nrow.tag[w]   = tag_s1;
					end
				end else if (rd.valid[w] && (!hit_n || (rd.age[w] <= old_age))) begin
					nrow.age[w] = age_up(rd.age[w]);
				end
			end
		end
	end

	always_comb begin
		ram_we    = cmd.clear || cmd.commit;
		ram_waddr = cmd.clear ? clr_q : set_s1;
		ram_wdata = cmd.clear ? '0 : ROW_W'(nrow);
		ram_raddr = cmd.load ? set_n : set_s1;
	end

	sacl_ram #(
		.WIDTH (ROW_W),
		.DEPTH (MAX_SETS)
	) u_row_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			acc_q  <= '0;
			hits_q <= '0;
			miss_q <= '0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + SET_W'(1);
			end
			if (cmd.commit) begin
				acc_q <= count_up(acc_q);
				if (hit_n) begin
					hits_q <= count_up(hits_q);
				end else begin
					miss_q <= count_up(miss_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q <= hit_n;
			way_q <= found;
			set_q <= set_s1;
		end
	end

	assign sts.clear_last = (clr_q == SET_W'(MAX_SETS - 1));

	assign hit          = hit_q;
	assign way          = way_q;
	assign set_index    = set_q;
	assign access_count = acc_q;
	assign hit_count    = hits_q;
	assign miss_count   = miss_q;

endmodule
